### design/prc_pkg.sv
// Shared types and constants for the point rotation pipeline.
`default_nettype none

package prc_pkg;

  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned ANGLE_BITS_DEF = 16;

  // Series arithmetic: terms are unsigned UQ2.30 and sums are signed Q3.30 values.
  localparam int unsigned FRAC_BITS    = 30;
  localparam int unsigned TERM_W       = 32;
  localparam int unsigned ACC_W        = 34;
  localparam int unsigned MAG_W        = 31;
  localparam int unsigned SERIES_TERMS = 7;

  localparam logic [TERM_W-1:0]       ONE_Q30     = 32'h4000_0000;
  localparam logic [TERM_W-1:0]       HALF_Q30    = 32'h2000_0000;
  localparam logic [TERM_W-1:0]       HALF_PI_Q30 = 32'd1686629713;
  localparam logic signed [ACC_W-1:0] ACC_ONE     = 34'sd1073741824;

  // Quadrant codes from the two top angle bits.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // Sine / cosine series state handed from cell to cell.
  typedef struct packed {
    logic signed [ACC_W-1:0] sin_acc;
    logic signed [ACC_W-1:0] cos_acc;
    logic [TERM_W-1:0]       sin_term;
    logic [TERM_W-1:0]       cos_term;
    logic [TERM_W-1:0]       sin_prod;
    logic [TERM_W-1:0]       cos_prod;
    logic [TERM_W-1:0]       ang_sq;
  } trig_t;

endpackage

`default_nettype wire

### design/point_rotate_about_center.sv
// Top level: rotate a Q16.16 point about a center by a binary angle.
// Pipeline: 2 front stages, 7 series cells of 3 stages each, and 5 back stages
//   including the output register.
// Throughput: one point per cycle while the output accepts results; every stage advances
//   when the one after it is empty or moving, so bubbles collapse under back-pressure.
// Reset: synchronous rst clears all stage valid bits; data registers are not reset.
`default_nettype none

module point_rotate_about_center
  import prc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,

  // point_x, point_y, center_x, center_y, turn_angle (lowest bit up), zero padded
  input  wire logic                                         s_axis_tvalid,
  output logic                                              s_axis_tready,
  input  wire logic [((4*COORD_BITS+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,

  // rotated_x, rotated_y (lowest bit up), zero padded
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata
);

  localparam int unsigned CB          = COORD_BITS;
  localparam int unsigned GEO_W       = 4*CB + 6;
  localparam int unsigned OUT_TDATA_W = ((2*CB+7)/8)*8;

  // Unpack the input transaction.
  logic signed [CB-1:0] point_x, point_y, center_x, center_y;
  logic [ANGLE_BITS-1:0] turn_angle;

  assign point_x    = s_axis_tdata[CB-1:0];
  assign point_y    = s_axis_tdata[2*CB-1:CB];
  assign center_x   = s_axis_tdata[3*CB-1:2*CB];
  assign center_y   = s_axis_tdata[4*CB-1:3*CB];
  assign turn_angle = s_axis_tdata[4*CB+ANGLE_BITS-1:4*CB];

  // Cell chain links: index k feeds cell k+1.
  logic             link_valid [SERIES_TERMS+1];
  logic             link_ready [SERIES_TERMS+1];
  trig_t            link_trig  [SERIES_TERMS+1];
  logic [GEO_W-1:0] link_geo   [SERIES_TERMS+1];

  logic [CB-1:0] rotated_x, rotated_y;

  // Front: quadrant split, angle in radians, angle squared, offset from center.
  prc_front #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .point_x    (point_x),
    .point_y    (point_y),
    .center_x   (center_x),
    .center_y   (center_y),
    .turn_angle (turn_angle),
    .out_valid  (link_valid[0]),
    .out_ready  (link_ready[0]),
    .out_trig   (link_trig[0]),
    .out_geo    (link_geo[0])
  );

  // Series cells: cell k forms the k-th sine and cosine terms and adds in
  // term k-1; the geometry rides along untouched.
  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_cell
    prc_cell #(
      .K     (k + 1),
      .GEO_W (GEO_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_trig   (link_trig[k]),
      .in_geo    (link_geo[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_trig  (link_trig[k+1]),
      .out_geo   (link_geo[k+1])
    );
  end

  // Back: last term, clamp, quadrant fold, rounded products, saturated sums.
  prc_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (link_valid[SERIES_TERMS]),
    .in_ready  (link_ready[SERIES_TERMS]),
    .in_trig   (link_trig[SERIES_TERMS]),
    .in_geo    (link_geo[SERIES_TERMS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y)
  );

  // Pack the result transaction; pad bits stay zero.
  assign m_axis_tdata = OUT_TDATA_W'({rotated_y, rotated_x});

`ifndef ASSERT_OFF
  a_ready_chain: assert property (@(posedge clk)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while the output side is taking results");
`endif

endmodule

`default_nettype wire

### design/prc_front.sv
// Front end: angle to radians, angle squared, center offset and its magnitude.
`default_nettype none

module prc_front
  import prc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic signed [COORD_BITS-1:0] center_x,
  input  wire logic signed [COORD_BITS-1:0] center_y,
  input  wire logic [ANGLE_BITS-1:0]        turn_angle,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output trig_t                             out_trig,
  output logic [4*COORD_BITS+5:0]           out_geo
);

  localparam int unsigned CB = COORD_BITS;

  logic v0, v1, en0, en1;

  // stage 0 registers
  logic [TERM_W-1:0]   theta;
  logic signed [CB:0]  dx, dy;
  logic [CB-1:0]       cx0, cy0;
  logic [1:0]          quad0;

  // stage 1 registers
  trig_t               trig1;
  logic [CB:0]         mdx, mdy;
  logic                sdx, sdy;
  logic [CB-1:0]       cx1, cy1;
  logic [1:0]          quad1;

  logic [TERM_W-1:0]   frac_u;
  logic [63:0]         rad_prod, sq_prod;
  logic [TERM_W-1:0]   theta_next;
  trig_t               trig_next;

  assign en1      = !v1 || out_ready;
  assign en0      = !v0 || en1;
  assign in_ready = en0;

  assign frac_u     = {turn_angle[ANGLE_BITS-3:0], {(34-ANGLE_BITS){1'b0}}};
  assign rad_prod   = 64'(frac_u) * 64'(HALF_PI_Q30);
  assign theta_next = rad_prod[63:32];
  assign sq_prod    = 64'(theta) * 64'(theta);

  always_comb begin
    trig_next          = '0;
    trig_next.sin_term = theta;
    trig_next.cos_term = ONE_Q30;
    trig_next.ang_sq   = sq_prod[FRAC_BITS+TERM_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      theta <= theta_next;
      dx    <= (CB+1)'(point_x) - (CB+1)'(center_x);
      dy    <= (CB+1)'(point_y) - (CB+1)'(center_y);
      cx0   <= center_x;
      cy0   <= center_y;
      quad0 <= turn_angle[ANGLE_BITS-1:ANGLE_BITS-2];
    end
    if (en1) begin
      trig1 <= trig_next;
      mdx   <= dx[CB] ? (~dx + 1'b1) : dx;
      mdy   <= dy[CB] ? (~dy + 1'b1) : dy;
      sdx   <= dx[CB];
      sdy   <= dy[CB];
      cx1   <= cx0;
      cy1   <= cy0;
      quad1 <= quad0;
    end
  end

  assign out_valid = v1;
  assign out_trig  = trig1;
  assign out_geo   = {quad1, cy1, cx1, sdy, mdy, sdx, mdx};

endmodule

`default_nettype wire

### design/prc_cell.sv
// One series cell: next sine and cosine Taylor terms and running sums.
`default_nettype none

module prc_cell
  import prc_pkg::*;
#(
  parameter int unsigned K     = 1,
  parameter int unsigned GEO_W = 4*COORD_BITS_DEF+6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire trig_t            in_trig,
  input  wire logic [GEO_W-1:0] in_geo,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output trig_t                 out_trig,
  output logic [GEO_W-1:0]      out_geo
);

  localparam int unsigned SIN_DIV = (2*K) * (2*K+1);
  localparam int unsigned COS_DIV = (2*K-1) * (2*K);
  localparam logic [TERM_W-1:0] SIN_D   = TERM_W'(SIN_DIV);
  localparam logic [TERM_W-1:0] COS_D   = TERM_W'(COS_DIV);
  localparam logic [TERM_W-1:0] SIN_RCP = TERM_W'((64'd1 << TERM_W) / SIN_DIV);
  localparam logic [TERM_W-1:0] COS_RCP = TERM_W'((64'd1 << TERM_W) / COS_DIV);
  localparam bit               ADD_PREV = (K % 2) == 1;

  logic va, vb, vc, ena, enb, enc;
  trig_t stage_a, stage_b, stage_c;
  trig_t stage_a_next, stage_b_next, stage_c_next;
  logic [GEO_W-1:0] geo_a, geo_b, geo_c;

  logic [63:0]             mul_s, mul_c, rcp_s, rcp_c;
  logic signed [ACC_W-1:0] prev_s, prev_c;
  logic [TERM_W-1:0]       qd_s, qd_c, rem_s, rem_c;

  assign enc      = !vc || out_ready;
  assign enb      = !vb || enc;
  assign ena      = !va || enb;
  assign in_ready = ena;

  // stage A: multiply by angle squared, fold the previous term into the sums
  assign mul_s  = 64'(in_trig.sin_term) * 64'(in_trig.ang_sq);
  assign mul_c  = 64'(in_trig.cos_term) * 64'(in_trig.ang_sq);
  assign prev_s = $signed({2'b00, in_trig.sin_term});
  assign prev_c = $signed({2'b00, in_trig.cos_term});

  always_comb begin
    stage_a_next          = in_trig;
    stage_a_next.sin_prod = mul_s[FRAC_BITS+TERM_W-1:FRAC_BITS];
    stage_a_next.cos_prod = mul_c[FRAC_BITS+TERM_W-1:FRAC_BITS];
    stage_a_next.sin_acc  = ADD_PREV ? in_trig.sin_acc + prev_s : in_trig.sin_acc - prev_s;
    stage_a_next.cos_acc  = ADD_PREV ? in_trig.cos_acc + prev_c : in_trig.cos_acc - prev_c;
  end

  // stage B: quotient estimate by reciprocal, low by at most one
  assign rcp_s = 64'(stage_a.sin_prod) * 64'(SIN_RCP);
  assign rcp_c = 64'(stage_a.cos_prod) * 64'(COS_RCP);

  always_comb begin
    stage_b_next          = stage_a;
    stage_b_next.sin_term = rcp_s[63:32];
    stage_b_next.cos_term = rcp_c[63:32];
  end

  // stage C: correct the estimate from the remainder
  assign qd_s  = stage_b.sin_term * SIN_D;
  assign qd_c  = stage_b.cos_term * COS_D;
  assign rem_s = stage_b.sin_prod - qd_s;
  assign rem_c = stage_b.cos_prod - qd_c;

  always_comb begin
    stage_c_next          = stage_b;
    stage_c_next.sin_term = (rem_s >= SIN_D) ? stage_b.sin_term + 1'b1 : stage_b.sin_term;
    stage_c_next.cos_term = (rem_c >= COS_D) ? stage_b.cos_term + 1'b1 : stage_b.cos_term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (ena) va <= in_valid;
      if (enb) vb <= va;
      if (enc) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      stage_a <= stage_a_next;
      geo_a   <= in_geo;
    end
    if (enb) begin
      stage_b <= stage_b_next;
      geo_b   <= geo_a;
    end
    if (enc) begin
      stage_c <= stage_c_next;
      geo_c   <= geo_b;
    end
  end

  assign out_valid = vc;
  assign out_trig  = stage_c;
  assign out_geo   = geo_c;

`ifndef ASSERT_OFF
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vb |-> (rem_s < (SIN_D << 1)) && (rem_c < (COS_D << 1)))
    else $error("reciprocal quotient estimate off by more than one");
`endif

endmodule

`default_nettype wire

### design/prc_back.sv
// Back end: clamp and fold sine/cosine, rotate the offset, add center, saturate.
`default_nettype none

module prc_back
  import prc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire trig_t                  in_trig,
  input  wire logic [4*COORD_BITS+5:0] in_geo,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [COORD_BITS-1:0]       rotated_x,
  output logic [COORD_BITS-1:0]       rotated_y
);

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned LO_W   = (CB + 1) / 2;
  localparam int unsigned HI_W   = CB + 1 - LO_W;
  localparam int unsigned FULL_W = CB + MAG_W + 1;
  localparam int unsigned SUM_W  = CB + 4;
  localparam logic [CB:0] MAG_LIM = {1'b1, {CB{1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {5'b00000, {(CB-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {5'b11111, {(CB-1){1'b0}}};

  logic [4:0] vld, en;

  // unpacked geometry
  logic [CB:0]   g_mdx, g_mdy;
  logic          g_sdx, g_sdy;
  logic [CB-1:0] g_cx, g_cy;
  quad_t         g_quad;

  assign g_mdx  = in_geo[CB:0];
  assign g_sdx  = in_geo[CB+1];
  assign g_mdy  = in_geo[2*CB+2:CB+2];
  assign g_sdy  = in_geo[2*CB+3];
  assign g_cx   = in_geo[3*CB+3:2*CB+4];
  assign g_cy   = in_geo[4*CB+3:3*CB+4];
  assign g_quad = quad_t'(in_geo[4*CB+5:4*CB+4]);

  // stage 0 registers
  logic [MAG_W-1:0] mag_s, mag_c;
  logic             neg_s, neg_c;
  logic [CB:0]      mdx0, mdy0;
  logic             sdx0, sdy0;
  logic signed [CB-1:0] cx0, cy0, cx1, cy1, cx2, cy2, cx3, cy3;

  // stage 1..3 registers, one entry per product
  logic [LO_W+MAG_W-1:0] pp_lo [4];
  logic [HI_W+MAG_W-1:0] pp_hi [4];
  logic                  neg1 [4];
  logic                  neg2 [4];
  logic [CB:0]           prod_mag [4];
  logic signed [CB+1:0]  term [4];

  // stage 0 logic
  logic signed [ACC_W-1:0] sin_fin, cos_fin;
  logic [MAG_W-1:0]        s_clamp, c_clamp, mag_s_next, mag_c_next;
  logic                    neg_s_next, neg_c_next;

  // stage 1..4 logic
  logic [CB:0]           op_m [4];
  logic [MAG_W-1:0]      op_t [4];
  logic [FULL_W-1:0]     full [4];
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [CB-1:0]         sat_x, sat_y;

  assign en[4] = !vld[4] || out_ready;
  assign en[3] = !vld[3] || en[4];
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];
  assign in_ready = en[0];

  // subtract the last term, clamp to [0, 1.0]
  assign sin_fin = in_trig.sin_acc - $signed({2'b00, in_trig.sin_term});
  assign cos_fin = in_trig.cos_acc - $signed({2'b00, in_trig.cos_term});

  always_comb begin
    if (sin_fin < 0) s_clamp = '0;
    else if (sin_fin > ACC_ONE) s_clamp = MAG_W'(ONE_Q30);
    else s_clamp = sin_fin[MAG_W-1:0];
    if (cos_fin < 0) c_clamp = '0;
    else if (cos_fin > ACC_ONE) c_clamp = MAG_W'(ONE_Q30);
    else c_clamp = cos_fin[MAG_W-1:0];
  end

  // fold by quadrant into sign and magnitude
  always_comb begin
    unique case (g_quad)
      QUAD_0: begin
        mag_s_next = s_clamp; neg_s_next = 1'b0;
        mag_c_next = c_clamp; neg_c_next = 1'b0;
      end
      QUAD_1: begin
        mag_s_next = c_clamp; neg_s_next = 1'b0;
        mag_c_next = s_clamp; neg_c_next = 1'b1;
      end
      QUAD_2: begin
        mag_s_next = s_clamp; neg_s_next = 1'b1;
        mag_c_next = c_clamp; neg_c_next = 1'b1;
      end
      QUAD_3: begin
        mag_s_next = c_clamp; neg_s_next = 1'b1;
        mag_c_next = s_clamp; neg_c_next = 1'b0;
      end
      default: begin
        mag_s_next = s_clamp; neg_s_next = 1'b0;
        mag_c_next = c_clamp; neg_c_next = 1'b0;
      end
    endcase
  end

  // products: dx*cos, dy*sin, dx*sin, dy*cos
  assign op_m[0] = mdx0;
  assign op_m[1] = mdy0;
  assign op_m[2] = mdx0;
  assign op_m[3] = mdy0;
  assign op_t[0] = mag_c;
  assign op_t[1] = mag_s;
  assign op_t[2] = mag_s;
  assign op_t[3] = mag_c;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      full[i] = (FULL_W'(pp_hi[i]) << LO_W) + FULL_W'(pp_lo[i]) + FULL_W'(HALF_Q30);
    end
  end

  // x = dx*cos - dy*sin + cx, y = dx*sin + dy*cos + cy
  assign sum_x = SUM_W'(term[0]) - SUM_W'(term[1]) + SUM_W'(cx3);
  assign sum_y = SUM_W'(term[2]) + SUM_W'(term[3]) + SUM_W'(cy3);

  always_comb begin
    if (sum_x > SUM_MAX) sat_x = SUM_MAX[CB-1:0];
    else if (sum_x < SUM_MIN) sat_x = SUM_MIN[CB-1:0];
    else sat_x = sum_x[CB-1:0];
    if (sum_y > SUM_MAX) sat_y = SUM_MAX[CB-1:0];
    else if (sum_y < SUM_MIN) sat_y = SUM_MIN[CB-1:0];
    else sat_y = sum_y[CB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < 5; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag_s <= mag_s_next;
      mag_c <= mag_c_next;
      neg_s <= neg_s_next;
      neg_c <= neg_c_next;
      mdx0  <= g_mdx;
      mdy0  <= g_mdy;
      sdx0  <= g_sdx;
      sdy0  <= g_sdy;
      cx0   <= g_cx;
      cy0   <= g_cy;
    end
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        pp_lo[i] <= (LO_W+MAG_W)'(op_m[i][LO_W-1:0]) * (LO_W+MAG_W)'(op_t[i]);
        pp_hi[i] <= (HI_W+MAG_W)'(op_m[i][CB:LO_W]) * (HI_W+MAG_W)'(op_t[i]);
      end
      neg1[0] <= sdx0 ^ neg_c;
      neg1[1] <= sdy0 ^ neg_s;
      neg1[2] <= sdx0 ^ neg_s;
      neg1[3] <= sdy0 ^ neg_c;
      cx1     <= cx0;
      cy1     <= cy0;
    end
    if (en[2]) begin
      for (int i = 0; i < 4; i++) begin
        prod_mag[i] <= full[i][CB+FRAC_BITS:FRAC_BITS];
        neg2[i]     <= neg1[i];
      end
      cx2 <= cx1;
      cy2 <= cy1;
    end
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        term[i] <= neg2[i] ? -$signed({1'b0, prod_mag[i]}) : $signed({1'b0, prod_mag[i]});
      end
      cx3 <= cx2;
      cy3 <= cy2;
    end
    if (en[4]) begin
      rotated_x <= sat_x;
      rotated_y <= sat_y;
    end
  end

  assign out_valid = vld[4];

`ifndef ASSERT_OFF
  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (mag_s <= MAG_W'(ONE_Q30)) && (mag_c <= MAG_W'(ONE_Q30)))
    else $error("folded sine or cosine magnitude above one");

  a_prod_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (prod_mag[0] <= MAG_LIM) && (prod_mag[1] <= MAG_LIM) &&
               (prod_mag[2] <= MAG_LIM) && (prod_mag[3] <= MAG_LIM))
    else $error("rounded product magnitude exceeds coordinate range");
`endif

endmodule

`default_nettype wire

### sim/tb_point_rotate_about_center.sv
// Testbench for point_rotate_about_center: streamed points checked against a local rotation predictor.
module tb_point_rotate_about_center;
  timeunit 1ns;
  timeprecision 1ps;

  import prc_pkg::*;

  localparam int CW           = COORD_BITS_DEF;
  localparam int AW           = ANGLE_BITS_DEF;
  localparam int IN_W         = ((4*CW+AW+7)/8)*8;
  localparam int OUT_W        = ((2*CW+7)/8)*8;
  localparam int CYCLE_LIMIT  = 200000;
  // Pipeline is 28 deep; give it some slack after the last result.
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 40;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] UNIT  = CW'(65536);   // 1.0 in Q16.16
  localparam logic signed [CW-1:0] NEG1  = '1;           // one LSB below zero
  localparam logic signed [CW-1:0] LSB1  = CW'(1);

  localparam logic [AW-1:0] TURN_EIGHTH  = AW'(1) << (AW-3);
  localparam logic [AW-1:0] TURN_QUARTER = AW'(1) << (AW-2);
  localparam logic [AW-1:0] TURN_HALF    = AW'(1) << (AW-1);
  localparam logic [AW-1:0] TURN_3Q      = TURN_HALF + TURN_QUARTER;
  localparam logic [AW-1:0] ANGLE_TOP    = '1;

  // One input transaction: point, center, angle.
  typedef struct {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [AW-1:0]        angle;
  } rot_job_t;

  // One output transaction: the rotated point.
  typedef struct {
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
  } rot_point_t;

  logic             clk;
  logic             rst           = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  // Rotated points still owed by the block, oldest first.
  rot_point_t pending_points[$];
  int         mismatch_count = 0;

  // Traffic shaping knobs, flipped by the test tasks.
  bit feed_gaps   = 1'b1;
  bit sink_stalls = 1'b1;
  int hold_cycles = 0;

  point_rotate_about_center #(
    .COORD_BITS(CW),
    .ANGLE_BITS(AW)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sine and cosine of a binary angle as Q1.30 values, quadrant folded in.
  // Within a quadrant both come from truncated Taylor series on the angle
  // in radians, each sum clamped to [0, 1.0].
  function automatic void quadrant_sin_cos(input logic [AW-1:0] angle,
                                           output longint sn, output longint cs);
    logic [63:0] frac, theta, theta_sq, s_term, c_term, divisor;
    longint      s_sum, c_sum, one;
    one      = longint'(ONE_Q30);
    frac     = 64'(angle[AW-3:0]) << (34 - AW);
    theta    = (frac * 64'(HALF_PI_Q30)) >> 32;
    theta_sq = (theta * theta) >> FRAC_BITS;
    s_term   = theta;
    c_term   = 64'(ONE_Q30);
    s_sum    = longint'(theta);
    c_sum    = one;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      divisor = 64'((2*k) * (2*k+1));
      s_term  = ((s_term * theta_sq) >> FRAC_BITS) / divisor;
      divisor = 64'((2*k-1) * (2*k));
      c_term  = ((c_term * theta_sq) >> FRAC_BITS) / divisor;
      if (k % 2) begin
        s_sum -= signed'(s_term);
        c_sum -= signed'(c_term);
      end else begin
        s_sum += signed'(s_term);
        c_sum += signed'(c_term);
      end
    end
    if (s_sum < 0) s_sum = 0;
    else if (s_sum > one) s_sum = one;
    if (c_sum < 0) c_sum = 0;
    else if (c_sum > one) c_sum = one;
    case (quad_t'(angle[AW-1 -: 2]))
      QUAD_0: begin sn = s_sum;  cs = c_sum;  end
      QUAD_1: begin sn = c_sum;  cs = -s_sum; end
      QUAD_2: begin sn = -s_sum; cs = -c_sum; end
      QUAD_3: begin sn = -c_sum; cs = s_sum;  end
    endcase
  endfunction

  // v * t / 2^30, rounded half away from zero (sign handled on magnitudes).
  function automatic longint round_mul_q30(input longint v, input longint t);
    logic        neg;
    logic [63:0] mv, mt, mag;
    neg = (v < 0) != (t < 0);
    mv  = (v < 0) ? -v : v;
    mt  = (t < 0) ? -t : t;
    mag = (mv * mt + (64'd1 << (FRAC_BITS-1))) >> FRAC_BITS;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [CW-1:0] saturate_coord(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CW-1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  // Difference is taken at 64 bits so it never wraps; sums are exact too.
  function automatic rot_point_t rotate_about_center(input rot_job_t job);
    rot_point_t res;
    longint     sn, cs, dx, dy;
    quadrant_sin_cos(job.angle, sn, cs);
    dx     = longint'(job.px) - longint'(job.cx);
    dy     = longint'(job.py) - longint'(job.cy);
    res.rx = saturate_coord(round_mul_q30(dx, cs) - round_mul_q30(dy, sn) + longint'(job.cx));
    res.ry = saturate_coord(round_mul_q30(dx, sn) + round_mul_q30(dy, cs) + longint'(job.cy));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic rot_job_t make_job(input logic signed [CW-1:0] px, py, cx, cy,
                                        input logic [AW-1:0] angle);
    rot_job_t job;
    job.px    = px;
    job.py    = py;
    job.cx    = cx;
    job.cy    = cy;
    job.angle = angle;
    return job;
  endfunction

  // Mix rails, full-range words and modest values around the origin.
  function automatic logic signed [CW-1:0] random_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          3:       return NEG1;
          default: return UNIT;
        endcase
      end
      1, 2, 3, 4: return CW'($urandom);
      default:    return CW'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endcase
  endfunction

  // Hit quadrant boundaries and their neighbors often; otherwise any angle.
  function automatic logic [AW-1:0] random_angle();
    case ($urandom_range(0, 7))
      0:       return AW'($urandom_range(0, 3)) << (AW-2);
      1:       return (AW'($urandom_range(0, 3)) << (AW-2)) + AW'(1);
      2:       return (AW'($urandom_range(0, 3)) << (AW-2)) - AW'(1);
      default: return AW'($urandom);
    endcase
  endfunction

  function automatic rot_job_t random_job(input bit about_origin);
    rot_job_t job;
    job.px    = random_coord();
    job.py    = random_coord();
    job.cx    = about_origin ? '0 : random_coord();
    job.cy    = about_origin ? '0 : random_coord();
    job.angle = random_angle();
    return job;
  endfunction

  // Offer one transaction at the falling edge, with a random gap first when
  // gaps are enabled; hold it until the block takes it, then log the
  // expected point. tvalid stays high on return so back-to-back items flow.
  task automatic send_job(input rot_job_t job);
    logic [IN_W-1:0] word;
    word                  = '0;
    word[CW-1:0]          = job.px;
    word[2*CW-1:CW]       = job.py;
    word[3*CW-1:2*CW]     = job.cx;
    word[4*CW-1:3*CW]     = job.cy;
    word[4*CW+AW-1:4*CW]  = job.angle;
    @(negedge clk);
    while (feed_gaps && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_points.push_back(rotate_about_center(job));
  endtask

  // Drop tvalid so the last word is not taken again, then wait for every
  // owed point to come out.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("ERROR at %0t ns: %s got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  // Drive tready at the falling edge: a counted hold-off wins, else random
  // stalls about 16 percent of the time, else always ready.
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else if (sink_stalls) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 16);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare every output transaction with the oldest pending point.
  always @(posedge clk) begin
    rot_point_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.rx = m_axis_tdata[CW-1:0];
      got.ry = m_axis_tdata[2*CW-1:CW];
      if (pending_points.size() == 0) begin
        report_mismatch("result with nothing pending, rotated_x", 64'(got.rx), '0);
      end else begin
        want = pending_points.pop_front();
        if (got.rx !== want.rx) report_mismatch("rotated_x", 64'(got.rx), 64'(want.rx));
        if (got.ry !== want.ry) report_mismatch("rotated_y", 64'(got.ry), 64'(want.ry));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Quarter-turn boundaries, angle rails, saturation, wide differences and
  // rounding of single-LSB products.
  task automatic test_directed();
    send_job(make_job(UNIT, '0, '0, '0, '0));
    send_job(make_job(UNIT, '0, '0, '0, TURN_QUARTER));
    send_job(make_job(UNIT, '0, '0, '0, TURN_HALF));
    send_job(make_job(UNIT, '0, '0, '0, TURN_3Q));
    send_job(make_job(UNIT, UNIT, '0, '0, ANGLE_TOP));
    send_job(make_job(UNIT, UNIT, '0, '0, AW'(1)));
    send_job(make_job(UNIT, '0, '0, '0, TURN_EIGHTH));
    send_job(make_job(UNIT, UNIT, '0, '0, TURN_QUARTER - AW'(1)));
    // Overflow: the diagonal grows by sqrt(2) and saturates.
    send_job(make_job(C_MAX, C_MAX, '0, '0, TURN_EIGHTH));
    send_job(make_job(C_MIN, C_MIN, '0, '0, TURN_EIGHTH));
    send_job(make_job(C_MAX, C_MIN, '0, '0, TURN_3Q));
    // Point minus center needs the extra bit here.
    send_job(make_job(C_MAX, C_MIN, C_MIN, C_MAX, TURN_HALF));
    send_job(make_job(C_MIN, C_MAX, C_MAX, C_MIN, '0));
    send_job(make_job(C_MIN, C_MAX, C_MAX, C_MIN, TURN_HALF));
    send_job(make_job(C_MIN, C_MIN, C_MAX, C_MAX, TURN_QUARTER));
    send_job(make_job(C_MAX, C_MAX, C_MAX, C_MAX, TURN_EIGHTH));
    send_job(make_job('0, '0, '0, '0, '0));
    send_job(make_job(NEG1, NEG1, LSB1, LSB1, TURN_HALF - AW'(1)));
    // Single-LSB differences land on rounding boundaries.
    send_job(make_job(LSB1, '0, '0, '0, TURN_EIGHTH));
    send_job(make_job(NEG1, LSB1, '0, '0, TURN_EIGHTH));
    send_job(make_job(CW'(229376), -CW'(147456), UNIT, UNIT, TURN_QUARTER));
    send_job(make_job(C_MIN, C_MAX, C_MIN, C_MAX, ANGLE_TOP));
    wait_drained();
  endtask

  task automatic test_origin_random();
    repeat (150) send_job(random_job(1'b1));
    wait_drained();
  endtask

  task automatic test_mixed_random();
    repeat (500) send_job(random_job(1'b0));
    wait_drained();
  endtask

  // Stretch with no gaps and no stalls: one transaction per cycle.
  task automatic test_steady_stream();
    feed_gaps   = 1'b0;
    sink_stalls = 1'b0;
    repeat (150) send_job(random_job($urandom_range(0, 3) == 0));
    wait_drained();
    feed_gaps   = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // Hold the output off long enough for the pipeline to fill and push back
  // on the input while items keep coming.
  task automatic test_output_hold();
    feed_gaps   = 1'b0;
    hold_cycles = 400;
    repeat (100) send_job(random_job(1'b0));
    wait_drained();
    feed_gaps   = 1'b1;
  endtask

  // Watchdog: end the run if it takes far longer than any correct run could.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("point_rotate_about_center test failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_origin_random();
    test_mixed_random();
    test_steady_stream();
    test_output_hold();

    // Drop tvalid, let anything stray come out, then judge.
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("point_rotate_about_center test passed");
    end else begin
      $display("point_rotate_about_center test failed");
    end
    $finish;
  end

endmodule

### files.f
design/prc_pkg.sv
design/prc_front.sv
design/prc_cell.sv
design/prc_back.sv
design/point_rotate_about_center.sv
sim/tb_point_rotate_about_center.sv
